/* rtl/core/mrf_pkg.sv */
package mrf_pkg;

    // Command codes carried on s_cmd
    typedef enum logic [2:0] {
        CMD_READ       = 3'd0,
        CMD_WRITE_REG  = 3'd1,
        CMD_WRITE_HI   = 3'd2,
        CMD_WRITE_LO   = 3'd3,
        CMD_PC_INC     = 3'd4,
        CMD_REL_JUMP   = 3'd5,
        CMD_ABS_JUMP   = 3'd6,
        CMD_REGION_JMP = 3'd7
    } cmd_t;

    localparam int unsigned DEFAULT_REG_COUNT = 32;
    localparam int unsigned INDEX_W           = 5;
    localparam int unsigned DATA_W            = 32;

    localparam logic [DATA_W-1:0] PC_RESET       = 32'h8002_0000;
    localparam logic [DATA_W-1:0] SP_RESET       = 32'hBFFF_FF00;
    localparam int unsigned       SP_INDEX       = 29;
    localparam logic [DATA_W-1:0] REGION_HI_MASK = 32'hF000_0000;
    localparam logic [DATA_W-1:0] REGION_LO_MASK = 32'h0FFF_FFFF;
    localparam logic [DATA_W-1:0] PC_STEP        = 32'd4;

    // Write strobes from the decode into the register storage
    typedef struct packed {
        logic gpr_we;
        logic hi_we;
        logic lo_we;
    } reg_wr_t;

endpackage

/* rtl/core/mrf_regs.sv */
module mrf_regs
    import mrf_pkg::*;
#(
    parameter int unsigned REG_COUNT = DEFAULT_REG_COUNT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  reg_wr_t              wr,
    input  logic [INDEX_W-1:0]   index,
    input  logic [DATA_W-1:0]    wdata,
    output logic [DATA_W-1:0]    rdata,
    output logic [DATA_W-1:0]    hi_q,
    output logic [DATA_W-1:0]    lo_q
);

    localparam int unsigned IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [DATA_W-1:0] gpr_reg [REG_COUNT];
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] lo_reg;
    logic              index_ok;
    logic [IDX_W-1:0]  addr;

    // Register zero and indexes past the end are not backed by storage
    assign index_ok = (index != '0) && ({1'b0, index} < (INDEX_W + 1)'(REG_COUNT));
    assign addr     = IDX_W'(index);

    assign rdata = index_ok ? gpr_reg[addr] : '0;
    assign hi_q  = hi_reg;
    assign lo_q  = lo_reg;

    // General registers, stack pointer entry has its own reset value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < int'(REG_COUNT); i++) begin
                gpr_reg[i] <= (i == int'(SP_INDEX)) ? SP_RESET : '0;
            end
        end else if (wr.gpr_we && index_ok) begin
            gpr_reg[addr] <= wdata;
        end
    end

    // HI / LO
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hi_reg <= '0;
            lo_reg <= '0;
        end else begin
            if (wr.hi_we) hi_reg <= wdata;
            if (wr.lo_we) lo_reg <= wdata;
        end
    end

endmodule

/* rtl/core/mrf_pc.sv */
module mrf_pc
    import mrf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  cmd_t              cmd,
    input  logic [DATA_W-1:0] jump_offset,
    input  logic [DATA_W-1:0] jump_target,
    output logic [DATA_W-1:0] pc_next,
    output logic              err
);

    logic [DATA_W-1:0] pc_reg;
    logic [DATA_W-1:0] region_addr;

    assign region_addr = (pc_reg & REGION_HI_MASK) | (jump_target & REGION_LO_MASK);

    // Next PC and alignment check
    always_comb begin
        pc_next = pc_reg;
        err     = 1'b0;
        case (cmd)
            CMD_PC_INC: pc_next = pc_reg + PC_STEP;
            CMD_REL_JUMP: begin
                if (jump_offset[1:0] != 2'b00) err = 1'b1;
                else                            pc_next = pc_reg + jump_offset;
            end
            CMD_ABS_JUMP: begin
                if (jump_target[1:0] != 2'b00) err = 1'b1;
                else                            pc_next = jump_target;
            end
            CMD_REGION_JMP: begin
                if (region_addr[1:0] != 2'b00) err = 1'b1;
                else                            pc_next = region_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_RESET;
        end else if (en) begin
            pc_reg <= pc_next;
        end
    end

endmodule

/* rtl/core/mips_register_file_with_pc.sv */
// Each command passes the input register, then the result register, which drives the m_* outputs.
// Throughput: one item per cycle unless m_ready stalls; the state update and result capture share a cycle.
// Stalls on m_ready hold both stages; one more item is taken while a result waits.
// Reset (aresetn low, synchronous): PC = 0x80020000, register 29 = 0xBFFFFF00,
// all other registers, HI and LO zero, both pipeline stages empty.
module mips_register_file_with_pc
    import mrf_pkg::*;
#(
    parameter int unsigned REG_COUNT = DEFAULT_REG_COUNT
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_cmd,
    input  logic [INDEX_W-1:0]       s_reg_index,
    input  logic [DATA_W-1:0]        s_write_value,
    input  logic signed [DATA_W-1:0] s_jump_offset,
    input  logic [DATA_W-1:0]        s_jump_target,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DATA_W-1:0]        m_read_value,
    output logic [DATA_W-1:0]        m_hi_value,
    output logic [DATA_W-1:0]        m_lo_value,
    output logic [DATA_W-1:0]        m_pc_value,
    output logic                     m_unaligned_error
);

    logic               in_valid_reg;
    cmd_t               cmd_reg;
    logic [INDEX_W-1:0] index_reg;
    logic [DATA_W-1:0]  wdata_reg;
    logic [DATA_W-1:0]  offset_reg;
    logic [DATA_W-1:0]  target_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] read_reg;
    logic [DATA_W-1:0] hi_out_reg;
    logic [DATA_W-1:0] lo_out_reg;
    logic [DATA_W-1:0] pc_out_reg;
    logic              err_reg;

    logic              advance;
    logic              exec;
    reg_wr_t           wr;
    logic [DATA_W-1:0] rdata;
    logic [DATA_W-1:0] hi_q;
    logic [DATA_W-1:0] lo_q;
    logic [DATA_W-1:0] pc_next;
    logic              pc_err;

    // Pipeline flow control
    assign advance = !out_valid_reg || m_ready;
    assign exec    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg    <= cmd_t'(s_cmd);
            index_reg  <= s_reg_index;
            wdata_reg  <= s_write_value;
            offset_reg <= s_jump_offset;
            target_reg <= s_jump_target;
        end
    end

    // Decode write strobes, gated by execution
    always_comb begin
        wr.gpr_we = exec && (cmd_reg == CMD_WRITE_REG);
        wr.hi_we  = exec && (cmd_reg == CMD_WRITE_HI);
        wr.lo_we  = exec && (cmd_reg == CMD_WRITE_LO);
    end

    mrf_regs #(
        .REG_COUNT (REG_COUNT)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .index   (index_reg),
        .wdata   (wdata_reg),
        .rdata   (rdata),
        .hi_q    (hi_q),
        .lo_q    (lo_q)
    );

    mrf_pc u_pc (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (exec),
        .cmd         (cmd_reg),
        .jump_offset (offset_reg),
        .jump_target (target_reg),
        .pc_next     (pc_next),
        .err         (pc_err)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec) begin
            read_reg   <= rdata;
            hi_out_reg <= hi_q;
            lo_out_reg <= lo_q;
            pc_out_reg <= pc_next;
            err_reg    <= pc_err;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_read_value      = read_reg;
    assign m_hi_value        = hi_out_reg;
    assign m_lo_value        = lo_out_reg;
    assign m_pc_value        = pc_out_reg;
    assign m_unaligned_error = err_reg;

endmodule

/* bench/mips_register_file_with_pc_tb.sv */
`timescale 1ns / 1ps

module mips_register_file_with_pc_tb;
    import mrf_pkg::*;

    localparam int unsigned NUM_REGS       = DEFAULT_REG_COUNT;
    localparam int          RANDOM_ITEMS   = 1900;
    localparam int          CALM_ITEMS     = 250;   // tail of the run with no idling
    localparam int          HOLD_AFTER     = 300;   // results before the long receiver hold
    localparam int          HOLD_CYCLES    = 80;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          MAX_REPORTS    = 10;

    // One command as offered on the input channel
    typedef struct {
        cmd_t                     cmd;
        logic [INDEX_W-1:0]       idx;
        logic [DATA_W-1:0]        wval;
        logic signed [DATA_W-1:0] offs;
        logic [DATA_W-1:0]        tgt;
    } regfile_cmd_t;

    // What the block reports for one command
    typedef struct {
        logic [DATA_W-1:0] rd;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] pc;
        logic              err;
    } regfile_view_t;

    logic                     aclk;
    logic                     aresetn       = 1'b0;
    logic                     s_valid       = 1'b0;
    logic                     s_ready;
    logic [2:0]               s_cmd         = '0;
    logic [INDEX_W-1:0]       s_reg_index   = '0;
    logic [DATA_W-1:0]        s_write_value = '0;
    logic signed [DATA_W-1:0] s_jump_offset = '0;
    logic [DATA_W-1:0]        s_jump_target = '0;
    logic                     m_valid;
    logic                     m_ready       = 1'b0;
    logic [DATA_W-1:0]        m_read_value;
    logic [DATA_W-1:0]        m_hi_value;
    logic [DATA_W-1:0]        m_lo_value;
    logic [DATA_W-1:0]        m_pc_value;
    logic                     m_unaligned_error;

    // Shadow copy of the architectural state
    logic [DATA_W-1:0] gpr_shadow [NUM_REGS];
    logic [DATA_W-1:0] hi_shadow;
    logic [DATA_W-1:0] lo_shadow;
    logic [DATA_W-1:0] pc_shadow;

    regfile_cmd_t  cmd_queue[$];
    regfile_view_t expected_snapshots[$];

    int   src_gap        = 0;
    int   sink_gap       = 0;
    int   hold_left      = 0;
    logic hold_done      = 1'b0;
    logic calm_phase     = 1'b0;
    int   results_seen   = 0;
    int   cmds_sent      = 0;
    int   directed_count = 0;
    int   refused_jumps  = 0;
    int   mismatch_count = 0;
    int   idle_cycles    = 0;

    mips_register_file_with_pc #(
        .REG_COUNT(NUM_REGS)
    ) u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_reg_index       (s_reg_index),
        .s_write_value     (s_write_value),
        .s_jump_offset     (s_jump_offset),
        .s_jump_target     (s_jump_target),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_read_value      (m_read_value),
        .m_hi_value        (m_hi_value),
        .m_lo_value        (m_lo_value),
        .m_pc_value        (m_pc_value),
        .m_unaligned_error (m_unaligned_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Apply one command to the shadow state; returns the expected report
    function automatic regfile_view_t advance_regfile(regfile_cmd_t c);
        regfile_view_t     v;
        logic              idx_ok;
        logic [DATA_W-1:0] region_pc;
        idx_ok = (c.idx != 0) && (c.idx < NUM_REGS);
        v.rd   = idx_ok ? gpr_shadow[c.idx] : '0;
        v.hi   = hi_shadow;
        v.lo   = lo_shadow;
        v.err  = 1'b0;
        case (c.cmd)
            CMD_WRITE_REG: begin
                if (idx_ok) gpr_shadow[c.idx] = c.wval;
            end
            CMD_WRITE_HI: hi_shadow = c.wval;
            CMD_WRITE_LO: lo_shadow = c.wval;
            CMD_PC_INC:   pc_shadow = pc_shadow + PC_STEP;
            CMD_REL_JUMP: begin
                if (c.offs[1:0] != 2'b00) v.err = 1'b1;
                else pc_shadow = pc_shadow + c.offs;
            end
            CMD_ABS_JUMP: begin
                if (c.tgt[1:0] != 2'b00) v.err = 1'b1;
                else pc_shadow = c.tgt;
            end
            CMD_REGION_JMP: begin
                region_pc = (pc_shadow & REGION_HI_MASK) | (c.tgt & REGION_LO_MASK);
                if (region_pc[1:0] != 2'b00) v.err = 1'b1;
                else pc_shadow = region_pc;
            end
            default: ;
        endcase
        v.pc = pc_shadow;
        return v;
    endfunction

    // Word with a bias toward the corners
    function automatic logic [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(0, 31);
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cmd(cmd_t cmd, int idx, logic [DATA_W-1:0] wval,
                           logic [DATA_W-1:0] offs, logic [DATA_W-1:0] tgt);
        regfile_cmd_t c;
        c.cmd  = cmd;
        c.idx  = idx[INDEX_W-1:0];
        c.wval = wval;
        c.offs = offs;
        c.tgt  = tgt;
        cmd_queue.push_back(c);
    endtask

    // Sender: pops the next command when the channel is free and no random gap is pending
    always @(posedge aclk) begin : driver
        regfile_cmd_t nxt;
        if (!aresetn) begin
            s_valid    <= 1'b0;
            src_gap    <= 0;
            calm_phase <= 1'b0;
        end else begin
            calm_phase <= (cmd_queue.size() < CALM_ITEMS);
            if (!s_valid || s_ready) begin
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (cmd_queue.size() != 0) begin
                    nxt = cmd_queue.pop_front();
                    s_valid       <= 1'b1;
                    s_cmd         <= nxt.cmd;
                    s_reg_index   <= nxt.idx;
                    s_write_value <= nxt.wval;
                    s_jump_offset <= nxt.offs;
                    s_jump_target <= nxt.tgt;
                    if (!calm_phase && $urandom_range(0, 9) == 0)
                        src_gap <= $urandom_range(1, 9);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stall bursts plus one long hold to back up the pipe
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_gap  <= 0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end else if (sink_gap != 0) begin
            m_ready  <= 1'b0;
            sink_gap <= sink_gap - 1;
        end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            m_ready  <= 1'b0;
            sink_gap <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on input transfers, check on result transfers
    always @(posedge aclk) begin : monitor
        regfile_cmd_t  taken;
        regfile_view_t seen;
        regfile_view_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen.rd  = m_read_value;
                seen.hi  = m_hi_value;
                seen.lo  = m_lo_value;
                seen.pc  = m_pc_value;
                seen.err = m_unaligned_error;
                results_seen <= results_seen + 1;
                if (expected_snapshots.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("[%0t] unexpected result: rd=%h hi=%h lo=%h pc=%h err=%b",
                                 $realtime, seen.rd, seen.hi, seen.lo, seen.pc, seen.err);
                end else begin
                    want = expected_snapshots.pop_front();
                    if (seen.rd !== want.rd || seen.hi !== want.hi || seen.lo !== want.lo ||
                        seen.pc !== want.pc || seen.err !== want.err) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("[%0t] mismatch: exp rd=%h hi=%h lo=%h pc=%h err=%b",
                                     $realtime, want.rd, want.hi, want.lo, want.pc, want.err);
                            $display("            got rd=%h hi=%h lo=%h pc=%h err=%b",
                                     seen.rd, seen.hi, seen.lo, seen.pc, seen.err);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                taken.cmd  = cmd_t'(s_cmd);
                taken.idx  = s_reg_index;
                taken.wval = s_write_value;
                taken.offs = s_jump_offset;
                taken.tgt  = s_jump_target;
                want = advance_regfile(taken);
                expected_snapshots.push_back(want);
                cmds_sent++;
                if (want.err) refused_jumps++;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                sel;
        cmd_t              c;
        logic [DATA_W-1:0] wval;
        logic [DATA_W-1:0] offs;
        logic [DATA_W-1:0] tgt;

        // Shadow state after reset
        for (int i = 0; i < NUM_REGS; i++) gpr_shadow[i] = '0;
        if (SP_INDEX < NUM_REGS) gpr_shadow[SP_INDEX] = SP_RESET;
        hi_shadow = '0;
        lo_shadow = '0;
        pc_shadow = PC_RESET;

        // Directed: reset values, register zero, field extremes, every jump flavor
        add_cmd(CMD_READ,       0,  '0,           '0,           '0);
        add_cmd(CMD_READ,       29, '0,           '0,           '0);
        add_cmd(CMD_WRITE_REG,  0,  '1,           '0,           '0);
        add_cmd(CMD_READ,       0,  '0,           '0,           '0);
        add_cmd(CMD_WRITE_REG,  31, '1,           '0,           '0);
        add_cmd(CMD_WRITE_REG,  1,  '0,           '1,           '1);
        add_cmd(CMD_READ,       31, '0,           '0,           '0);
        add_cmd(CMD_WRITE_HI,   5,  '1,           '0,           '0);
        add_cmd(CMD_WRITE_LO,   6,  32'h5555_AAAA, '0,          '0);
        add_cmd(CMD_READ,       1,  '0,           '0,           '0);
        add_cmd(CMD_PC_INC,     0,  '0,           '0,           '0);
        add_cmd(CMD_REL_JUMP,   0,  '0,           32'hFFFF_FFFC, '0);
        add_cmd(CMD_REL_JUMP,   0,  '0,           32'h7FFF_FFFC, '0);
        add_cmd(CMD_REL_JUMP,   0,  '0,           32'h8000_0000, '0);
        add_cmd(CMD_REL_JUMP,   0,  '0,           32'h0000_0001, '0);
        add_cmd(CMD_REL_JUMP,   0,  '0,           32'h0000_0002, '0);
        add_cmd(CMD_REL_JUMP,   0,  '0,           '1,           '0);
        add_cmd(CMD_ABS_JUMP,   0,  '0,           '0,           32'hFFFF_FFFC);
        add_cmd(CMD_PC_INC,     0,  '0,           '0,           '0);  // wraps to zero
        add_cmd(CMD_ABS_JUMP,   0,  '0,           '0,           '1);
        add_cmd(CMD_ABS_JUMP,   0,  '0,           '0,           32'h0000_0002);
        add_cmd(CMD_REGION_JMP, 0,  '0,           '0,           32'hFFFF_FFFC);
        add_cmd(CMD_REGION_JMP, 0,  '0,           '0,           32'h0000_0001);
        add_cmd(CMD_ABS_JUMP,   0,  '0,           '0,           PC_RESET);
        add_cmd(CMD_REGION_JMP, 0,  '0,           '0,           '0);
        directed_count = cmd_queue.size();

        // Random mix, mostly aligned jumps so the PC keeps moving
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 20)      c = CMD_READ;
            else if (sel < 45) c = CMD_WRITE_REG;
            else if (sel < 50) c = CMD_WRITE_HI;
            else if (sel < 55) c = CMD_WRITE_LO;
            else if (sel < 68) c = CMD_PC_INC;
            else if (sel < 80) c = CMD_REL_JUMP;
            else if (sel < 90) c = CMD_ABS_JUMP;
            else               c = CMD_REGION_JMP;
            wval = pick_word();
            offs = pick_word();
            tgt  = pick_word();
            if (c == CMD_REL_JUMP && $urandom_range(0, 1) == 0)
                offs = $urandom_range(0, 8191) - 4096;
            if ($urandom_range(0, 3) != 0) begin
                offs[1:0] = 2'b00;
                tgt[1:0]  = 2'b00;
            end
            add_cmd(c, $urandom_range(0, 31), wval, offs, tgt);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every command to go in and every result to come out
        do @(negedge aclk);
        while (cmd_queue.size() != 0 || s_valid || expected_snapshots.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (expected_snapshots.size() != 0) begin
            mismatch_count += expected_snapshots.size();
            $display("%0d results never arrived", expected_snapshots.size());
        end

        $display("Sent %0d commands (%0d directed), checked %0d results, %0d jumps refused.",
                 cmds_sent, directed_count, results_seen, refused_jumps);
        $display("Receiver held off once for %0d cycles; %0d mismatches.",
                 HOLD_CYCLES, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
